// ===== src/lacs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacs_pkg
// Shared types, codes and the battery range table of the charger supervisor.
// ----------------------------------------------------------------------------
package lacs_pkg;

    localparam int TYPE_W         = 3;
    localparam int TYPE_COUNT_DEF = 5;
    localparam int ROWS           = 7;
    localparam int VAL_W          = 12;
    localparam int USB_W          = 8;
    localparam int LED_W          = 7;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    // battery status codes
    localparam logic [1:0] BS_NORMAL   = 2'd0;
    localparam logic [1:0] BS_REVERSED = 2'd1;
    localparam logic [1:0] BS_ERROR    = 2'd2;

    // supply status codes
    localparam logic [1:0] SS_CHARGE   = 2'd0;
    localparam logic [1:0] SS_MAINTAIN = 2'd1;
    localparam logic [1:0] SS_NONE     = 2'd2;
    localparam logic [1:0] SS_OVERVOLT = 2'd3;

    // usb status codes
    localparam logic [1:0] US_IDLE     = 2'd0;
    localparam logic [1:0] US_ONE_AMP  = 2'd1;
    localparam logic [1:0] US_TWO_AMP  = 2'd2;

    // display commands
    localparam logic [1:0] DISP_NONE    = 2'd0;
    localparam logic [1:0] DISP_NUM     = 2'd1;
    localparam logic [1:0] DISP_DEFAULT = 2'd2;

    // key codes
    localparam logic [2:0] KEY_NONE     = 3'd0;
    localparam logic [2:0] KEY_VOLTAGE  = 3'd1;
    localparam logic [2:0] KEY_CURRENT  = 3'd2;
    localparam logic [2:0] KEY_CAPACITY = 3'd3;
    localparam logic [2:0] KEY_PERCENT  = 3'd4;

    // led bit positions
    localparam int LED_REV  = 0;
    localparam int LED_ERR  = 1;
    localparam int LED_MODE = 2;
    localparam int LED_FIX  = 3;
    localparam int LED_CHG  = 4;
    localparam int LED_U1   = 5;
    localparam int LED_U2   = 6;

    // register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_USB_SPLIT = 1'b1;

    localparam logic [VAL_W-1:0] THRESHOLD_RST = 12'd10;
    localparam logic [USB_W-1:0] USB_SPLIT_RST = 8'd10;

    localparam logic [2:0] LAST_BS_RST = 3'd7;
    localparam logic [2:0] LAST_SS_RST = 3'd7;
    localparam logic [1:0] LAST_US_RST = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] battery_voltage;
        logic [VAL_W-1:0] supply_voltage;
        logic [VAL_W-1:0] battery_current;
        logic [USB_W-1:0] usb_current;
        logic             reversed;
        logic             aux_valid;
        logic [2:0]       key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       battery_status;
        logic [1:0]       supply_status;
        logic [1:0]       usb_status;
        logic             relay_on;
        logic [LED_W-1:0] led_bits;
        logic [1:0]       display_cmd;
        logic [VAL_W-1:0] display_value;
    } t_out_item;

    typedef struct packed {
        logic [VAL_W-1:0] present_threshold;
        logic [USB_W-1:0] usb_split;
    } t_cfg;

    typedef struct packed {
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic [VAL_W-1:0] nom;
        logic [VAL_W-1:0] maxv;
    } t_row;

    // battery range table, unused rows never match
    function automatic t_row range_row(input logic [TYPE_W-1:0] idx);
        t_row row;
        case (idx)
            3'd0:    row = '{lo: 12'd48,  hi: 12'd72,  nom: 12'd55,  maxv: 12'd73};
            3'd1:    row = '{lo: 12'd96,  hi: 12'd143, nom: 12'd114, maxv: 12'd145};
            3'd2:    row = '{lo: 12'd192, hi: 12'd286, nom: 12'd228, maxv: 12'd290};
            3'd3:    row = '{lo: 12'd288, hi: 12'd432, nom: 12'd331, maxv: 12'd438};
            3'd4:    row = '{lo: 12'd440, hi: 12'd576, nom: 12'd441, maxv: 12'd584};
            default: row = '{lo: 12'd4095, hi: 12'd0, nom: 12'd4095, maxv: 12'd4095};
        endcase
        return row;
    endfunction

endpackage

// ===== src/lacs_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacs_regs
// Configuration registers behind a simple APB slave; pready is held high.
// ----------------------------------------------------------------------------
module lacs_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lacs_pkg::ADDR_W-1:0] paddr,
    input  logic [lacs_pkg::DATA_W-1:0] pwdata,
    output logic [lacs_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lacs_pkg::t_cfg              o_cfg
);
    import lacs_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.present_threshold <= THRESHOLD_RST;
            r_cfg.usb_split         <= USB_SPLIT_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_THRESHOLD: r_cfg.present_threshold <= pwdata[VAL_W-1:0];
                REG_USB_SPLIT: r_cfg.usb_split         <= pwdata[USB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = DATA_W'(r_cfg.present_threshold);
            REG_USB_SPLIT: prdata = DATA_W'(r_cfg.usb_split);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== src/lacs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacs_core
// Status classification, relay and led tracking, display selection.
// ----------------------------------------------------------------------------
module lacs_core #(
    parameter int TYPE_COUNT = lacs_pkg::TYPE_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  lacs_pkg::t_in_item  i_item,
    input  lacs_pkg::t_cfg      i_cfg,
    output lacs_pkg::t_out_item o_result
);
    import lacs_pkg::*;

    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = TYPE_W'(TYPE_COUNT);

    logic [TYPE_W-1:0] r_type, n_type;
    logic [2:0]        r_last_bs, n_last_bs;
    logic [2:0]        r_last_ss, n_last_ss;
    logic [1:0]        r_last_us, n_last_us;
    logic              r_relay, n_relay;
    logic [LED_W-1:0]  r_led, n_led;

    t_row             w_cur_row;
    t_row             w_new_row;
    logic             w_found;
    logic             w_known;
    logic [1:0]       w_bs;
    logic [1:0]       w_ss;
    logic [1:0]       w_us;
    logic [1:0]       w_cmd;
    logic [VAL_W-1:0] w_val;

    assign w_cur_row = range_row(r_type);
    assign w_new_row = range_row(n_type);
    assign w_known   = n_type < TYPE_UNKNOWN;

    // battery classification and type latch
    always_comb begin
        n_type  = r_type;
        w_found = 1'b0;
        if (i_item.reversed) begin
            w_bs = BS_REVERSED;
        end else if (i_item.battery_voltage >= i_cfg.present_threshold) begin
            if (r_type >= TYPE_UNKNOWN) begin
                w_bs = BS_ERROR;
                for (int t = 0; t < ROWS; t++) begin
                    if (!w_found && t < TYPE_COUNT
                        && i_item.battery_voltage >= range_row(TYPE_W'(t)).lo
                        && i_item.battery_voltage <= range_row(TYPE_W'(t)).hi) begin
                        n_type  = TYPE_W'(t);
                        w_found = 1'b1;
                        w_bs    = BS_NORMAL;
                    end
                end
            end else if (i_item.battery_voltage >= w_cur_row.lo
                         && i_item.battery_voltage <= w_cur_row.hi) begin
                w_bs = BS_NORMAL;
            end else begin
                w_bs = BS_ERROR;
            end
        end else begin
            w_bs = BS_ERROR;
        end
    end

    // supply and usb classification
    always_comb begin
        w_ss = SS_NONE;
        if (w_known && w_bs == BS_NORMAL) begin
            if (i_item.aux_valid && i_item.supply_voltage <= w_new_row.maxv
                && i_item.supply_voltage >= w_new_row.nom) begin
                w_ss = (i_item.battery_voltage < w_new_row.nom) ? SS_MAINTAIN : SS_CHARGE;
            end else if (i_item.supply_voltage > w_new_row.maxv) begin
                w_ss = SS_OVERVOLT;
            end
        end

        if (i_item.usb_current != '0 && i_item.usb_current < i_cfg.usb_split) begin
            w_us = US_ONE_AMP;
        end else if (i_item.usb_current > i_cfg.usb_split) begin
            w_us = US_TWO_AMP;
        end else begin
            w_us = US_IDLE;
        end
    end

    // transitions in order: battery, supply, usb; the last writer wins
    always_comb begin
        n_led     = r_led;
        n_relay   = r_relay;
        n_last_bs = r_last_bs;
        n_last_ss = r_last_ss;
        n_last_us = r_last_us;
        w_cmd     = DISP_NONE;
        w_val     = '0;

        if ({1'b0, w_bs} != r_last_bs) begin
            case (w_bs)
                BS_REVERSED: begin
                    n_led[LED_REV] = 1'b1;
                    n_relay        = 1'b0;
                end
                BS_NORMAL: begin
                    n_led[LED_ERR] = 1'b0;
                    n_led[LED_REV] = 1'b0;
                    w_cmd          = DISP_NUM;
                    w_val          = i_item.battery_voltage;
                end
                default: begin
                    w_cmd          = DISP_DEFAULT;
                    n_led[LED_ERR] = 1'b1;
                    n_relay        = 1'b0;
                end
            endcase
            n_last_bs = {1'b0, w_bs};
        end

        if ({1'b0, w_ss} != r_last_ss) begin
            case (w_ss)
                SS_OVERVOLT: begin
                    n_led[LED_MODE] = 1'b1;
                    n_led[LED_FIX]  = 1'b0;
                    n_led[LED_CHG]  = 1'b0;
                    n_relay         = 1'b0;
                end
                SS_CHARGE: begin
                    n_led[LED_CHG] = 1'b1;
                    n_led[LED_FIX] = 1'b0;
                    n_relay        = 1'b1;
                end
                SS_MAINTAIN: begin
                    n_led[LED_FIX] = 1'b1;
                    n_led[LED_CHG] = 1'b0;
                    n_relay        = 1'b1;
                end
                default: begin
                    n_led[LED_FIX] = 1'b0;
                    n_led[LED_CHG] = 1'b0;
                    n_relay        = 1'b0;
                end
            endcase
            n_last_ss = {1'b0, w_ss};
        end

        // not charging lights the usb2a led just as two amp does
        if (w_us != r_last_us) begin
            n_led[LED_U1] = (w_us == US_ONE_AMP);
            n_led[LED_U2] = (w_us != US_ONE_AMP);
            n_last_us     = w_us;
        end

        if (w_bs == BS_NORMAL) begin
            case (i_item.key) inside
                KEY_VOLTAGE, KEY_CAPACITY: begin
                    w_cmd = DISP_NUM;
                    w_val = i_item.battery_voltage;
                end
                KEY_CURRENT: begin
                    w_cmd = DISP_NUM;
                    w_val = i_item.battery_current;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type    <= TYPE_UNKNOWN;
            r_last_bs <= LAST_BS_RST;
            r_last_ss <= LAST_SS_RST;
            r_last_us <= LAST_US_RST;
            r_relay   <= 1'b0;
            r_led     <= '0;
        end else if (i_step) begin
            r_type    <= n_type;
            r_last_bs <= n_last_bs;
            r_last_ss <= n_last_ss;
            r_last_us <= n_last_us;
            r_relay   <= n_relay;
            r_led     <= n_led;
        end
    end

    assign o_result.battery_status = w_bs;
    assign o_result.supply_status  = w_ss;
    assign o_result.usb_status     = w_us;
    assign o_result.relay_on       = n_relay;
    assign o_result.led_bits       = n_led;
    assign o_result.display_cmd    = w_cmd;
    assign o_result.display_value  = w_val;

endmodule

// ===== src/lead_acid_charger_supervisor.sv =====
`timescale 1ns / 1ps
// path: an accepted input transaction is held in the input register, then its
//   result is registered in the result stage once that stage is free or emptying
// throughput: one item per cycle while the output is not stalled, set by the
//   single classify pass between the input register and the result register
// reset: synchronous active low; clears both stages, battery type to unknown,
//   last statuses to none seen, relay and leds off, registers to defaults
// ----------------------------------------------------------------------------
// lead_acid_charger_supervisor
// Charger supervisor top level: input stage, status logic, result stage.
// ----------------------------------------------------------------------------
module lead_acid_charger_supervisor #(
    parameter int TYPE_COUNT = lacs_pkg::TYPE_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  lacs_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lacs_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lacs_pkg::ADDR_W-1:0] paddr,
    input  logic [lacs_pkg::DATA_W-1:0] pwdata,
    output logic [lacs_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import lacs_pkg::*;

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_move;
    logic      w_accept;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    lacs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lacs_core #(
        .TYPE_COUNT (TYPE_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_move),
        .i_item   (r_s1_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // the input stage drains whenever the result stage is free or emptying
    assign w_move     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_move;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept || (r_s1_valid && !w_move);
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item <= i_in_data;
        end
        if (w_move) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

`ifndef SYNTH
    // the relay is only ever driven on by a charge or maintain transition
    a_relay_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.relay_on
        |-> (o_out_data.led_bits[LED_CHG] || o_out_data.led_bits[LED_FIX]))
        else $error("relay on without charge or maintain led");

    a_disp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.display_cmd != DISP_NUM
        |-> o_out_data.display_value == '0)
        else $error("display value set without a number command");

    // a supply state other than none needs a normal battery
    a_supply_needs_batt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.supply_status != SS_NONE
        |-> o_out_data.battery_status == BS_NORMAL)
        else $error("supply classified with battery not normal");

    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> o_out_valid)
        else $error("transaction lost between stages");
`endif

endmodule
